/* rtl/fpdf_pkg.sv */
`default_nettype none

package fpdf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_W          = 4;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_W         = 4;

  localparam logic [FRAC_W-1:0]  MAX_FRAC    = 4'd9;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_POINT = 8'd46;
  localparam logic [DIGIT_W-1:0] DD_LIMIT    = 4'd5;
  localparam logic [DIGIT_W-1:0] DD_ADJUST   = 4'd3;

endpackage

`default_nettype wire

/* rtl/fpdf_if.sv */
`default_nettype none

interface fpdf_in_if #(
  parameter int VALUE_WIDTH = fpdf_pkg::VALUE_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [VALUE_WIDTH-1:0]      value;
  logic [fpdf_pkg::FRAC_W-1:0] frac_digits;

  modport source (output valid, output value, output frac_digits, input ready);
  modport sink   (input valid, input value, input frac_digits, output ready);
endinterface

interface fpdf_out_if;
  logic                        valid;
  logic                        ready;
  logic [fpdf_pkg::CHAR_W-1:0] character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

/* rtl/fixed_point_decimal_formatter.sv */
// Sequence: an accepted item is shifted into the BCD digits bit by bit, each suppressed
// leading zero of the integer part is shifted out, then one character per cycle follows
// while the output is free. A new item is taken only in the idle state, after the last
// character of the previous one is registered, since the single digit-correct-and-shift
// unit and the character sequencer serve one item at a time; output stalls hold it off.
// Reset: synchronous, active low; clears the sequencer and the output valid flag.
`default_nettype none

module fixed_point_decimal_formatter #(
  parameter int VALUE_WIDTH = fpdf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fpdf_in_if.sink          in_ch,
  fpdf_out_if.source       out_ch
);
  import fpdf_pkg::*;

  localparam int DIG_RAW = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NDIG    = (DIG_RAW > int'(MAX_FRAC) + 1) ? DIG_RAW : int'(MAX_FRAC) + 1;
  localparam int BCD_W   = NDIG * DIGIT_W;
  localparam int POS_W   = $clog2(NDIG);
  localparam int CNT_W   = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_SKIP, S_INT, S_POINT, S_FRAC
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [FRAC_W-1:0]      k_r, k_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [DIGIT_W-1:0]     top_digit;
  logic [POS_W-1:0]       k_pos;
  logic [BCD_W-1:0]       bcd_shl;
  logic [CHAR_W-1:0]      top_char;
  logic                   out_free;
  logic                   in_take;

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];
  assign k_pos     = POS_W'(k_r);
  assign bcd_shl   = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
  assign top_char  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_take   = in_ch.valid && (state_r == S_IDLE);

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= DD_LIMIT) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + DD_ADJUST;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          bin_nxt   = in_ch.value;
          bcd_nxt   = '0;
          k_nxt     = (in_ch.frac_digits > MAX_FRAC) ? MAX_FRAC : in_ch.frac_digits;
          cnt_nxt   = '0;
          pos_nxt   = POS_W'(NDIG - 1);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
        bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if ((top_digit == '0) && (pos_r > k_pos)) begin
          bcd_nxt = bcd_shl;
          pos_nxt = pos_r - 1'b1;
        end else begin
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = top_char;
          out_last_nxt  = 1'b0;
          bcd_nxt       = bcd_shl;
          if (pos_r == k_pos) begin
            state_nxt = S_POINT;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      S_POINT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_POINT;
          out_last_nxt  = (k_r == '0);
          if (k_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = k_pos - 1'b1;
            state_nxt = S_FRAC;
          end
        end
      end
      S_FRAC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = top_char;
          out_last_nxt  = (pos_r == '0);
          bcd_nxt       = bcd_shl;
          if (pos_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    k_r        <= k_nxt;
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // The conversion always leaves the digit pointer at the most significant digit.
  a_conv_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && cnt_r == CNT_W'(VALUE_WIDTH - 1)) |=>
      (pos_r == POS_W'(NDIG - 1)))
    else $error("digit pointer not at the top after conversion");

  // Integer digits lie at or above the point, fractional digits below it.
  a_int_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INT || state_r == S_SKIP) |-> (pos_r >= k_pos))
    else $error("integer digit emitted below the point");

  a_frac_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRAC) |-> (pos_r < k_pos))
    else $error("fractional digit emitted above the point");

  // Every digit leaving the converter is a valid decimal digit.
  a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INT || state_r == S_FRAC) |-> (top_digit <= 4'd9))
    else $error("converter produced a non-decimal digit");

endmodule

`default_nettype wire

/* dv/fixed_point_decimal_formatter_tb.sv */
`default_nettype none

module fixed_point_decimal_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpdf_pkg::*;

  localparam int VALUE_WIDTH   = VALUE_WIDTH_DEF;
  localparam int RADIX         = 10;
  localparam int RANDOM_ITEMS  = 140;
  localparam int HOLD_AFTER    = 40;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = VALUE_WIDTH + 32;
  localparam int PRINT_LIMIT   = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_char_t;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic [FRAC_W-1:0]      frac;
    string                  text;
  } stim_row_t;

  logic clk;
  logic rst_n;

  fpdf_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
  fpdf_out_if                             out_ch ();

  fixed_point_decimal_formatter #(.VALUE_WIDTH(VALUE_WIDTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  out_char_t pending_chars[$];
  int        mismatches     = 0;
  int        accepted_items = 0;
  bit        calm           = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    mismatches++;
  endtask

  // Digits are collected least significant first, then queued in reading order.
  function automatic void format_decimal(input logic [VALUE_WIDTH-1:0] value,
                                         input logic [FRAC_W-1:0]      frac_req);
    logic [63:0]       rest;
    logic [FRAC_W-1:0] nfrac;
    logic [CHAR_W-1:0] reversed[$];
    out_char_t         ch;
    rest  = 64'(value);
    nfrac = (frac_req > MAX_FRAC) ? MAX_FRAC : frac_req;
    for (int i = 0; i < int'(nfrac); i++) begin
      reversed.push_back(ASCII_ZERO + CHAR_W'(rest % RADIX));
      rest = rest / RADIX;
    end
    reversed.push_back(ASCII_POINT);
    do begin
      reversed.push_back(ASCII_ZERO + CHAR_W'(rest % RADIX));
      rest = rest / RADIX;
    end while (rest != 0);
    for (int i = reversed.size() - 1; i >= 0; i--) begin
      ch.character = reversed[i];
      ch.last      = (i == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [VALUE_WIDTH-1:0] value,
                           input logic [FRAC_W-1:0]      frac);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.value       <= value;
    in_ch.frac_digits <= frac;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accepted_items++;
  endtask

  initial begin : stimulus
    stim_row_t              directed_rows[];
    out_char_t              ch;
    logic [VALUE_WIDTH-1:0] value;
    logic [FRAC_W-1:0]      frac;
    logic [63:0]            scale;
    int                     drain_cycles;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.value       <= '0;
    in_ch.frac_digits <= '0;

    directed_rows = '{
      '{32'd0,          4'd0,  "0."},
      '{32'd0,          4'd9,  "0.000000000"},
      '{32'hFFFF_FFFF,  4'd0,  "4294967295."},
      '{32'hFFFF_FFFF,  4'd9,  "4.294967295"},
      '{32'hFFFF_FFFF,  4'd15, "4.294967295"},
      '{32'd0,          4'd15, "0.000000000"},
      '{32'd1,          4'd0,  "1."},
      '{32'd5,          4'd3,  "0.005"},
      '{32'd12345,      4'd2,  ""},
      '{32'd1000000000, 4'd9,  "1.000000000"},
      '{32'd999999999,  4'd9,  "0.999999999"},
      '{32'd10,         4'd1,  "1.0"},
      '{32'd9,          4'd1,  "0.9"},
      '{32'h8000_0000,  4'd10, "2.147483648"},
      '{32'h7FFF_FFFF,  4'd5,  ""},
      '{32'd123456789,  4'd8,  "1.23456789"},
      '{32'd65535,      4'd4,  "6.5535"},
      '{32'd42,         4'd12, "0.000000042"},
      '{32'd0,          4'd1,  "0.0"},
      '{32'hAAAA_AAAA,  4'd7,  ""},
      '{32'h5555_5555,  4'd2,  ""},
      '{32'd100,        4'd11, ""}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].value, directed_rows[r].frac);
      if (directed_rows[r].text.len() == 0) begin
        format_decimal(directed_rows[r].value, directed_rows[r].frac);
      end else begin
        for (int i = 0; i < directed_rows[r].text.len(); i++) begin
          ch.character = directed_rows[r].text[i];
          ch.last      = (i == directed_rows[r].text.len() - 1);
          pending_chars.push_back(ch);
        end
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 70 && n < 100);
      frac = ($urandom_range(0, 99) < 85) ? FRAC_W'($urandom_range(0, 9))
                                         : FRAC_W'($urandom_range(10, 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: value = $urandom;
        4, 5:       value = $urandom_range(0, 9999);
        6, 7: begin
          // The integer part stays zero, so the fraction keeps its leading zeros.
          scale = 1;
          for (int i = 0; i < int'((frac > MAX_FRAC) ? MAX_FRAC : frac); i++) begin
            scale = scale * RADIX;
          end
          value = $urandom_range(0, 32'(scale - 1));
        end
        8: begin
          scale = 1;
          repeat ($urandom_range(0, 9)) scale = scale * RADIX;
          value = VALUE_WIDTH'(scale + $urandom_range(0, 2) - 1);
        end
        default: value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
      send_item(value, frac);
      format_decimal(value, frac);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    drain_cycles = 0;
    while (pending_chars.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    end

    if (mismatches == 0) begin
      $display("[fixed_point_decimal_formatter] OK");
    end else begin
      $display("[fixed_point_decimal_formatter] ERROR");
    end
    $finish;
  end

  // The receiver stalls at random; once, it holds off for a long stretch so that
  // the block fills up and refuses further items.
  initial begin : receiver
    bit long_hold_done;
    int gap;
    long_hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold_done && accepted_items >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                  out_ch.character, out_ch.last));
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.character !== want.character) begin
          report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                    out_ch.character, want.character));
        end
        if (out_ch.last !== want.last) begin
          report_mismatch($sformatf("last %0b, wanted %0b on character 0x%02h",
                                    out_ch.last, want.last, want.character));
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("[fixed_point_decimal_formatter] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
